/* rtl/core/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types and constants for the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // CORDIC start value, K * 2^30
    localparam int CORDIC_K        = 652032875;
    localparam int ATAN_COUNT      = 28;
    localparam logic [31:0] TURN_GAIN_RESET = 32'd51590656;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rot;
        logic trig;
        logic mul_s;
        logic mul_c;
        logic fin;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic rot_last;
    } t_status;

    // Arctangent table, 2^32 binary angle units per turn
    function automatic logic [29:0] f_atan(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10680862;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/ddo_ctrl.sv */
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for one odometry update: load, CORDIC rotations, trig rounding,
// two multiply steps and the final pose write into the output register.
// ----------------------------------------------------------------------------
module ddo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ddo_pkg::t_status i_status,
    output ddo_pkg::t_cmd   o_cmd
);
    import ddo_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROT  = 6'b000010,
        S_TRIG = 6'b000100,
        S_MULS = 6'b001000,
        S_MULC = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                if (i_status.rot_last) n_state = S_TRIG;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = S_MULS;
            end
            S_MULS: begin
                o_cmd.mul_s = 1'b1;
                n_state     = S_MULC;
            end
            S_MULC: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on write, drop when the transaction completes
    always_comb begin
        if (o_cmd.fin)          n_out_valid = 1'b1;
        else if (!i_out_stall)  n_out_valid = 1'b0;
        else                    n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/ddo_datapath.sv */
// ----------------------------------------------------------------------------
// ddo_datapath
// Wheel differences, iterative CORDIC, shared multiplier, saturating pose
// accumulators, heading accumulator and the output register.
// ----------------------------------------------------------------------------
module ddo_datapath #(
    parameter int POS_BITS  = 32,
    parameter int TRIG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_left_position,
    input  logic signed [31:0]  i_right_position,
    input  ddo_pkg::t_cmd       i_cmd,
    output ddo_pkg::t_status    o_status,
    output logic signed [31:0]  o_pose_x,
    output logic signed [31:0]  o_pose_y,
    output logic [31:0]         o_pose_heading
);
    import ddo_pkg::*;

    localparam int ITERS  = (TRIG_BITS + 4 < ATAN_COUNT) ? TRIG_BITS + 4 : ATAN_COUNT;
    localparam int CNT_W  = $clog2(ITERS);
    localparam int SH     = 31 - TRIG_BITS;
    localparam int PW     = 34 + TRIG_BITS;
    localparam int AW     = ((POS_BITS > PW) ? POS_BITS : PW) + 2;

    logic [31:0]                r_gain;
    logic signed [31:0]         r_prev_l, r_prev_r;
    logic signed [POS_BITS-1:0] r_acc_x, r_acc_y;
    logic [31:0]                r_heading;
    logic signed [33:0]         r_sum, r_diff;
    logic signed [33:0]         r_x, r_y;
    logic signed [31:0]         r_z;
    logic [1:0]                 r_q;
    logic [CNT_W-1:0]           r_it;
    logic signed [TRIG_BITS-1:0] r_sin, r_cos;
    logic signed [PW-1:0]       r_prod;
    logic [39:0]                r_turn;
    logic signed [31:0]         r_o_x, r_o_y;
    logic [31:0]                r_o_h;

    // Round a Q.30 value to Q1.(TRIG_BITS-1) and saturate
    function automatic logic signed [TRIG_BITS-1:0] f_trig(input logic signed [34:0] v);
        logic signed [35:0] t;
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = (36'sd1 <<< (TRIG_BITS - 1)) - 36'sd1;
        lo = -hi - 36'sd1;
        t  = (36'(v) + (36'sd1 <<< (SH - 1))) >>> SH;
        if (t > hi)      t = hi;
        else if (t < lo) t = lo;
        return t[TRIG_BITS-1:0];
    endfunction

    // Add a step to a pose and saturate to POS_BITS
    function automatic logic signed [POS_BITS-1:0] f_acc(
        input logic signed [POS_BITS-1:0] acc,
        input logic signed [PW-1:0]       prod
    );
        logic signed [AW-1:0] d;
        logic signed [AW-1:0] s;
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = (AW'(1) <<< (POS_BITS - 1)) - AW'(1);
        lo = -hi - AW'(1);
        d  = (AW'(prod) + (AW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
        s  = AW'(acc) + d;
        if (s > hi)      s = hi;
        else if (s < lo) s = lo;
        return s[POS_BITS-1:0];
    endfunction

    logic signed [33:0] xs, ys, az;
    logic signed [31:0] atn;
    logic signed [34:0] ex, ey, sv, cv;
    logic signed [AW-1:0] ox, oy;
    logic [39:0] d40, plo, phi;
    logic [55:0] mlo, mhi;
    logic [39:0] trnd;

    assign o_status.rot_last = (r_it == CNT_W'(ITERS - 1));

    // CORDIC step terms
    assign xs  = r_x >>> r_it;
    assign ys  = r_y >>> r_it;
    assign atn = $signed({2'b00, f_atan(5'(r_it))});
    assign az  = '0;

    // Quadrant fold
    assign ex = 35'(r_x);
    assign ey = 35'(r_y);
    always_comb begin
        unique case (r_q)
            2'd0: begin sv = ey;  cv = ex;  end
            2'd1: begin sv = ex;  cv = -ey; end
            2'd2: begin sv = -ey; cv = -ex; end
            default: begin sv = -ex; cv = ey; end
        endcase
    end

    // Turn product in two 16-bit halves of the gain
    assign d40  = 40'(r_diff);
    assign mlo  = d40 * r_gain[15:0];
    assign mhi  = d40 * r_gain[31:16];
    assign plo  = mlo[39:0];
    assign phi  = {mhi[23:0], 16'd0};
    assign trnd = r_turn + 40'd128;

    assign ox = AW'(f_acc(r_acc_x, r_prod));
    assign oy = AW'(f_acc(r_acc_y, r_prod));

    // Configuration register and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= TURN_GAIN_RESET;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_heading <= '0;
            r_it      <= '0;
        end else begin
            if (i_cfg_we) r_gain <= i_cfg_data;
            if (i_cmd.load) begin
                r_prev_l <= i_left_position;
                r_prev_r <= i_right_position;
                r_it     <= '0;
            end
            if (i_cmd.rot && !o_status.rot_last) r_it <= r_it + CNT_W'(1);
            if (i_cmd.mul_c) r_acc_x <= ox[POS_BITS-1:0];
            if (i_cmd.fin) begin
                r_acc_y   <= oy[POS_BITS-1:0];
                r_heading <= r_heading + trnd[39:8];
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum  <= (34'(i_left_position) - 34'(r_prev_l))
                    + (34'(i_right_position) - 34'(r_prev_r));
            r_diff <= (34'(i_right_position) - 34'(r_prev_r))
                    - (34'(i_left_position) - 34'(r_prev_l));
            r_x    <= 34'(CORDIC_K);
            r_y    <= az;
            r_z    <= $signed({2'b00, r_heading[29:0]});
            r_q    <= r_heading[31:30];
        end
        if (i_cmd.rot) begin
            if (!r_z[31]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atn;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atn;
            end
        end
        if (i_cmd.trig) begin
            r_sin <= f_trig(sv);
            r_cos <= f_trig(cv);
        end
        if (i_cmd.mul_s) begin
            r_prod <= PW'(r_sum * r_sin);
            r_turn <= plo;
        end
        if (i_cmd.mul_c) begin
            r_prod <= PW'(r_sum * r_cos);
            r_turn <= r_turn + phi;
        end
        // Load the whole pose into the output register in one step
        if (i_cmd.fin) begin
            r_o_x <= 32'(r_acc_x);
            r_o_y <= oy[31:0];
            r_o_h <= r_heading + trnd[39:8];
        end
    end

    assign o_pose_x       = r_o_x;
    assign o_pose_y       = r_o_y;
    assign o_pose_heading = r_o_h;

endmodule

/* rtl/core/differential_drive_odometry_top.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Fixed-point differential drive odometry with CORDIC sin/cos.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry absolute left and right
//   wheel positions (Q24.8 cm). Output channel: o_out_valid / i_out_stall
//   carry the updated pose x, y (Q24.8 cm, saturating) and heading
//   (binary angle, wraps).
//   Each transaction runs from acceptance through the CORDIC rotation loop,
//   one iteration a cycle, then trig rounding, two multiply steps and the
//   final write of the result into the output register.
//   One item is processed at a time; o_in_stall is high while busy, so a
//   new item is accepted only after the previous result is in the output
//   register. A new item may be accepted while that result still waits.
//   When the receiver stalls, the finished pose holds in the datapath
//   until the output register frees; the pending result does not change.
//   i_cfg_we writes turn_gain; write only while idle.
//   Reset (synchronous, active low) clears the pose, heading and last
//   positions and restores the default turn gain.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top #(
    parameter int POS_BITS  = 32,
    parameter int TRIG_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_pose_heading
);
    import ddo_pkg::*;

    t_cmd    cmd;
    t_status status;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_datapath #(
        .POS_BITS  (POS_BITS),
        .TRIG_BITS (TRIG_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_left_position  (i_left_position),
        .i_right_position (i_right_position),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_pose_x         (o_pose_x),
        .o_pose_y         (o_pose_y),
        .o_pose_heading   (o_pose_heading)
    );

    // Busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A result appears only at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    // Work sequencer commands are exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for differential_drive_odometry_top. A queue-fed
// driver sends wheel positions in bursts, a pose predictor tracks the
// expected x, y and heading, and a monitor compares each result under
// random output stalls. The turn gain is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
    import ddo_pkg::*;

    localparam int POS_BITS   = 32;
    localparam int TRIG_BITS  = 16;
    localparam int ROT_STEPS  = (TRIG_BITS + 4 < ATAN_COUNT) ? TRIG_BITS + 4 : ATAN_COUNT;
    localparam int LATENCY    = TRIG_BITS + 9;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
    } t_wheels;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        heading;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_left_position = '0;
    logic signed [31:0] i_right_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic [31:0]        o_pose_heading;

    differential_drive_odometry_top #(.POS_BITS(POS_BITS), .TRIG_BITS(TRIG_BITS)) DUT (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [31:0]        gain_q;
    logic signed [31:0] last_left, last_right;
    longint             pose_x_q, pose_y_q;
    logic [31:0]        heading_q;

    t_wheels pending_wheels[$];
    t_pose   expected_poses[$];
    int      errors = 0;
    bit      hold_sender = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_mode = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint to_trig(longint v);
        int sh;
        sh = 30 - (TRIG_BITS - 1);
        return clamp(floor_shift(v + (longint'(1) <<< (sh - 1)), sh), TRIG_BITS);
    endfunction

    // Fixed-length CORDIC on the low 30 bits, quadrant from the top two
    task automatic heading_trig(input logic [31:0] ang, output longint sn, output longint cs);
        longint cx, cy, z, xs, ys, s, c;
        cx = CORDIC_K;
        cy = 0;
        z  = longint'(ang[29:0]);
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = floor_shift(cx, i);
            ys = floor_shift(cy, i);
            if (z >= 0) begin
                cx -= ys; cy += xs; z -= longint'(f_atan(5'(i)));
            end else begin
                cx += ys; cy -= xs; z += longint'(f_atan(5'(i)));
            end
        end
        case (ang[31:30])
            2'd0: begin s = cy;  c = cx;  end
            2'd1: begin s = cx;  c = -cy; end
            2'd2: begin s = -cy; c = -cx; end
            default: begin s = -cx; c = cy; end
        endcase
        sn = to_trig(s);
        cs = to_trig(c);
    endtask

    // Advance the pose by one wheel sample
    task automatic predict_pose(input t_wheels w);
        longint dl, dr, travel, sn, cs, half;
        logic [63:0] prod;
        t_pose p;
        dl = longint'(w.left) - longint'(last_left);
        dr = longint'(w.right) - longint'(last_right);
        travel = dl + dr;
        half = longint'(1) <<< (TRIG_BITS - 1);
        last_left = w.left;
        last_right = w.right;
        heading_trig(heading_q, sn, cs);
        pose_x_q = clamp(pose_x_q + floor_shift(travel * sn + half, TRIG_BITS), POS_BITS);
        pose_y_q = clamp(pose_y_q + floor_shift(travel * cs + half, TRIG_BITS), POS_BITS);
        prod = 64'(dr - dl) * {32'd0, gain_q} + 64'd128;
        heading_q += prod[39:8];
        p.x = pose_x_q[31:0];
        p.y = pose_y_q[31:0];
        p.heading = heading_q;
        expected_poses.push_back(p);
    endtask

    // Driver: bursts and gaps, hold payload while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_pose({i_left_position, i_right_position});
                void'(pending_wheels.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
                    i_in_valid <= 1'b0;
                end else begin
                    // pick the next item; the one just taken is already gone
                    if (!hold_sender && pending_wheels.size() > 0) begin
                        t_wheels w;
                        w = pending_wheels[0];
                        i_in_valid <= 1'b1;
                        i_left_position <= w.left;
                        i_right_position <= w.right;
                        burst_left <= burst_left - 1;
                    end else begin
                        i_in_valid <= 1'b0;
                    end
                end
            end
        end
    end

    // Monitor: compare each pose transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    $display("%0t: unexpected pose x=%h y=%h hd=%h", $time,
                             o_pose_x, o_pose_y, o_pose_heading);
                    errors++;
                end else begin
                    t_pose e;
                    e = expected_poses.pop_front();
                    if (e.x !== o_pose_x) begin
                        $display("%0t: pose_x exp %h got %h", $time, e.x, o_pose_x);
                        errors++;
                    end
                    if (e.y !== o_pose_y) begin
                        $display("%0t: pose_y exp %h got %h", $time, e.y, o_pose_y);
                        errors++;
                    end
                    if (e.heading !== o_pose_heading) begin
                        $display("%0t: pose_heading exp %h got %h", $time,
                                 e.heading, o_pose_heading);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
            default: return 32'($urandom_range(0, 8000)) - 32'd4000;
        endcase
    endfunction

    task automatic queue_wheels(input logic [31:0] l, input logic [31:0] r);
        t_wheels w;
        w.left = l;
        w.right = r;
        pending_wheels.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_wheels.size() != 0 || expected_poses.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [31:0] g);
        i_cfg_we <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain_q = g;
        @(posedge i_clk);
    endtask

    // Random phase: smooth driving mostly, with large jumps mixed in
    task automatic random_drive(input int count);
        logic [31:0] l, r;
        l = last_left;
        r = last_right;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                l = rand_pos();
                r = rand_pos();
            end else begin
                l = l + 32'($urandom_range(0, 1200)) - 32'd600;
                r = r + 32'($urandom_range(0, 1200)) - 32'd600;
            end
            queue_wheels(l, r);
        end
    endtask

    initial begin
        gain_q = TURN_GAIN_RESET;
        last_left = '0;
        last_right = '0;
        pose_x_q = 0;
        pose_y_q = 0;
        heading_q = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: straight runs, spins, extremes, saturation
        queue_wheels(32'd256, 32'd256);
        queue_wheels(32'd512, 32'd0);
        queue_wheels(32'd512, 32'd2000);
        queue_wheels(32'h7fff_ffff, 32'h7fff_ffff);
        queue_wheels(32'h8000_0000, 32'h8000_0000);
        queue_wheels(32'h7fff_ffff, 32'h7fff_ffff);
        queue_wheels(32'h8000_0000, 32'h7fff_ffff);
        queue_wheels(32'h7fff_ffff, 32'h8000_0000);
        queue_wheels(32'hffff_ffff, 32'h0000_0000);
        queue_wheels(32'h5555_5555, 32'haaaa_aaaa);
        queue_wheels(32'haaaa_aaaa, 32'h5555_5555);
        queue_wheels(32'h0, 32'h0);
        for (int i = 1; i <= 8; i++) queue_wheels(32'h7fff_ffff, 32'h7fff_ffff - 32'(i));
        wait_idle();

        // Pause the sender mid-phase until every result is back, then resume
        random_drive(150);
        while (pending_wheels.size() > 75) @(posedge i_clk);
        hold_sender = 1'b1;
        while (i_in_valid || expected_poses.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_idle();

        write_gain(32'hffff_ffff);
        random_drive(150);
        wait_idle();
        write_gain(32'h0);
        random_drive(150);
        wait_idle();
        write_gain(32'h4000_0000);
        random_drive(150);
        wait_idle();
        write_gain($urandom());
        random_drive(150);
        wait_idle();
        write_gain(32'd1);
        random_drive(150);
        wait_idle();
        write_gain(TURN_GAIN_RESET);
        random_drive(180);
        wait_idle();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Timeout
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
